@@ rtl/core/cht_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// cht_pkg
// Shared types, codes and widths of the connection hash table.
// ============================================================================
package cht_pkg;

    localparam int TABLE_SLOTS_DEF = 256;

    localparam int ACT_W   = 3;
    localparam int KEY_W   = 64;
    localparam int HDL_W   = 16;
    localparam int XID_W   = 32;
    localparam int ST_W    = 3;
    localparam int ENTRY_W = KEY_W + HDL_W + XID_W;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_HDL_BY_KEY = 3'd2;
    localparam logic [ACT_W-1:0] ACT_KEY_BY_HDL = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TAKE_XID   = 3'd4;

    // Status codes.
    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd5;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_INS,
        MODE_KEY,
        MODE_HDL
    } scan_mode_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_UPDATE,
        S_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic scan_start;
        logic scan_step;
        logic upd_we;
        logic clr_we;
        logic out_load;
    } cht_cmd_t;

    typedef struct packed {
        scan_mode_t mode;
        logic       mod_done;
        logic       hit;
        logic       miss;
        logic       upd_need;
        logic       clr_last;
        logic       out_free;
    } cht_stat_t;

endpackage

@@ rtl/core/cht_req_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// cht_req_if
// Request channel of the connection hash table.
// ============================================================================
interface cht_req_if;
    import cht_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] key;
    logic [HDL_W-1:0] handle;
    logic [XID_W-1:0] xid_in;

    modport source (output valid, action, key, handle, xid_in, input ready);
    modport sink   (input valid, action, key, handle, xid_in, output ready);
endinterface

@@ rtl/core/cht_rsp_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// cht_rsp_if
// Response channel of the connection hash table.
// ============================================================================
interface cht_rsp_if;
    import cht_pkg::*;

    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] key_out;
    logic [HDL_W-1:0] handle_out;
    logic [XID_W-1:0] xid_out;

    modport source (output valid, status, key_out, handle_out, xid_out, input ready);
    modport sink   (input valid, status, key_out, handle_out, xid_out, output ready);
endinterface

@@ rtl/core/cht_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// cht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/core/cht_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// cht_ctrl
// Sequencer of the connection hash table: clearing pass, hashing, probe walk,
// slot update and response hand-off.
// ============================================================================
module cht_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cht_pkg::cht_stat_t stat,
    output cht_pkg::cht_cmd_t  cmd
);
    import cht_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (stat.mode == MODE_NONE)
                begin
                    state_next = S_RESP;
                end
                else if (stat.mod_done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.hit && stat.upd_need)
                begin
                    state_next = S_UPDATE;
                end
                else if (stat.hit || stat.miss)
                begin
                    state_next = S_RESP;
                end
            end
            S_UPDATE:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_we = 1'b1;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_MOD:
            begin
                cmd.mod_step   = 1'b1;
                cmd.scan_start = (stat.mode != MODE_NONE) && stat.mod_done;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            S_UPDATE:
            begin
                cmd.upd_we = 1'b1;
            end
            S_RESP:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule

@@ rtl/core/cht_datapath.sv @@
`timescale 1ns / 1ps
// ============================================================================
// cht_datapath
// Request registers, key hashing unit, probe pointer, slot compare, slot
// memory and response register of the connection hash table.
// ============================================================================
module cht_datapath #(
    parameter int TABLE_SLOTS = cht_pkg::TABLE_SLOTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cht_pkg::cht_cmd_t         cmd,
    output cht_pkg::cht_stat_t        stat,
    input  logic [cht_pkg::ACT_W-1:0] action,
    input  logic [cht_pkg::KEY_W-1:0] key,
    input  logic [cht_pkg::HDL_W-1:0] handle,
    input  logic [cht_pkg::XID_W-1:0] xid_in,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [cht_pkg::ST_W-1:0]  status,
    output logic [cht_pkg::KEY_W-1:0] key_out,
    output logic [cht_pkg::HDL_W-1:0] handle_out,
    output logic [cht_pkg::XID_W-1:0] xid_out
);
    import cht_pkg::*;

    localparam int IDX_W    = $clog2(TABLE_SLOTS);
    localparam bit POW2     = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam int NIB_STEP = 4;
    localparam int NIBBLES  = KEY_W / NIB_STEP;
    localparam int NCNT_W   = $clog2(NIBBLES + 1);
    localparam logic [IDX_W:0]    SLOTS_C  = (IDX_W + 1)'(TABLE_SLOTS);
    localparam logic [IDX_W:0]    LAST_C   = (IDX_W + 1)'(TABLE_SLOTS - 1);
    localparam logic [IDX_W-1:0]  TOP_IDX  = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [NCNT_W-1:0] NIB_DONE = NCNT_W'(NIBBLES);

    // Request registers.
    logic [ACT_W-1:0] act_reg;
    logic [KEY_W-1:0] key_reg;
    logic [HDL_W-1:0] hdl_reg;
    logic [XID_W-1:0] xid_reg;

    // Key modulo unit, four key bits per cycle.
    logic [KEY_W-1:0]  mod_sh_reg;
    logic [IDX_W:0]    mod_rem_reg;
    logic [IDX_W:0]    mod_rem_next;
    logic [NCNT_W-1:0] mod_cnt_reg;

    // Probe walk.
    logic [IDX_W-1:0] addr_reg;
    logic [IDX_W-1:0] addr_inc;
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W:0]   iss_cnt_reg;
    logic             rdv_reg;
    logic             rd_last_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             issue;

    // Found slot and result.
    logic [KEY_W-1:0] fnd_key_reg;
    logic [HDL_W-1:0] fnd_hdl_reg;
    logic [XID_W-1:0] fnd_xid_reg;
    logic [IDX_W-1:0] fnd_idx_reg;
    logic             found_reg;
    logic [ST_W-1:0]  res_status_reg;

    // Response register.
    logic             out_valid_reg;
    logic [ST_W-1:0]  out_status_reg;
    logic [KEY_W-1:0] out_key_reg;
    logic [HDL_W-1:0] out_hdl_reg;
    logic [XID_W-1:0] out_xid_reg;

    // Memory.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [HDL_W-1:0]   rd_hdl;
    logic [XID_W-1:0]   rd_xid;

    scan_mode_t mode;
    logic       key_eq;
    logic       slot_used;
    logic       match;

    cht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[ENTRY_W-1 -: KEY_W];
    assign rd_hdl = ram_rdata[XID_W +: HDL_W];
    assign rd_xid = ram_rdata[XID_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            key_reg <= key;
            hdl_reg <= handle;
            xid_reg <= xid_in;
        end
    end

    always_comb
    begin
        case (act_reg)
            ACT_INSERT:     mode = MODE_INS;
            ACT_REMOVE:     mode = MODE_HDL;
            ACT_KEY_BY_HDL: mode = MODE_HDL;
            ACT_HDL_BY_KEY: mode = (key_reg != '0) ? MODE_KEY : MODE_NONE;
            ACT_TAKE_XID:
            begin
                if (key_reg != '0)
                begin
                    mode = MODE_KEY;
                end
                else if (hdl_reg != '0)
                begin
                    mode = MODE_HDL;
                end
                else
                begin
                    mode = MODE_NONE;
                end
            end
            default:        mode = MODE_NONE;
        endcase
    end

    // Restoring remainder, one key bit per inner step.
    always_comb
    begin
        logic [IDX_W:0] r;
        r = mod_rem_reg;
        for (int i = 0; i < NIB_STEP; i++)
        begin
            r = {r[IDX_W-1:0], mod_sh_reg[KEY_W-1-i]};
            if (r >= SLOTS_C)
            begin
                r = r - SLOTS_C;
            end
        end
        mod_rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            mod_cnt_reg <= '0;
        end
        else if (cmd.mod_step && mod_cnt_reg != NIB_DONE)
        begin
            mod_cnt_reg <= mod_cnt_reg + NCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mod_sh_reg  <= key;
            mod_rem_reg <= '0;
        end
        else if (cmd.mod_step && mod_cnt_reg != NIB_DONE)
        begin
            mod_sh_reg  <= {mod_sh_reg[KEY_W-NIB_STEP-1:0], NIB_STEP'(0)};
            mod_rem_reg <= mod_rem_next;
        end
    end

    always_comb
    begin
        if (mode == MODE_HDL)
        begin
            start_idx = '0;
        end
        else if (POW2)
        begin
            start_idx = key_reg[IDX_W-1:0];
        end
        else
        begin
            start_idx = mod_rem_reg[IDX_W-1:0];
        end
    end

    assign addr_inc = (addr_reg == TOP_IDX) ? '0 : addr_reg + IDX_W'(1);
    assign issue    = cmd.scan_step && (iss_cnt_reg != SLOTS_C);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg    <= '0;
            iss_cnt_reg <= '0;
            rdv_reg     <= 1'b0;
            rd_last_reg <= 1'b0;
        end
        else
        begin
            // The read issued in the cycle of a hit is dropped, so that the
            // slot already found is not replaced by the one after it.
            rdv_reg <= issue && !stat.hit;
            if (cmd.clr_we)
            begin
                addr_reg <= addr_inc;
            end
            else if (cmd.scan_start)
            begin
                addr_reg    <= start_idx;
                iss_cnt_reg <= '0;
            end
            else if (issue)
            begin
                addr_reg    <= addr_inc;
                iss_cnt_reg <= iss_cnt_reg + (IDX_W + 1)'(1);
                rd_last_reg <= (iss_cnt_reg == LAST_C);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_idx_reg <= addr_reg;
        end
    end

    assign key_eq    = (rd_key == key_reg);
    assign slot_used = (rd_key != '0);

    always_comb
    begin
        case (mode)
            MODE_INS: match = key_eq || !slot_used;
            MODE_KEY: match = key_eq;
            MODE_HDL: match = slot_used && (rd_hdl == hdl_reg);
            default:  match = 1'b0;
        endcase
    end

    assign stat.mode     = mode;
    assign stat.mod_done = POW2 || (mode == MODE_HDL) || (mod_cnt_reg == NIB_DONE);
    assign stat.hit      = rdv_reg && match;
    assign stat.miss     = rdv_reg && rd_last_reg && !match;
    assign stat.upd_need = ((act_reg == ACT_INSERT) && !key_eq) ||
                           (act_reg == ACT_REMOVE) || (act_reg == ACT_TAKE_XID);
    assign stat.clr_last = (addr_reg == TOP_IDX);
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            res_status_reg <= ST_NOT_FOUND;
        end
        else if (cmd.load)
        begin
            found_reg      <= 1'b0;
            res_status_reg <= ST_NOT_FOUND;
        end
        else if (stat.hit)
        begin
            found_reg <= 1'b1;
            if (act_reg == ACT_INSERT)
            begin
                res_status_reg <= key_eq ? ST_DUPLICATE : ST_INSERTED;
            end
            else if (act_reg == ACT_REMOVE)
            begin
                res_status_reg <= ST_REMOVED;
            end
            else
            begin
                res_status_reg <= ST_FOUND;
            end
        end
        else if (stat.miss)
        begin
            res_status_reg <= (act_reg == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.hit)
        begin
            fnd_key_reg <= rd_key;
            fnd_hdl_reg <= rd_hdl;
            fnd_xid_reg <= rd_xid;
            fnd_idx_reg <= rd_idx_reg;
        end
    end

    // The clearing pass writes empty slots; updates write the found slot.
    assign ram_we    = cmd.clr_we || cmd.upd_we;
    assign ram_waddr = cmd.clr_we ? addr_reg : fnd_idx_reg;

    always_comb
    begin
        if (cmd.clr_we)
        begin
            ram_wdata = '0;
        end
        else
        begin
            case (act_reg)
                ACT_INSERT:   ram_wdata = {key_reg, hdl_reg, xid_reg};
                ACT_TAKE_XID: ram_wdata = {fnd_key_reg, fnd_hdl_reg,
                                           fnd_xid_reg + XID_W'(1)};
                default:      ram_wdata = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_key_reg    <= (found_reg && (act_reg == ACT_REMOVE ||
                               act_reg == ACT_KEY_BY_HDL || act_reg == ACT_TAKE_XID))
                              ? fnd_key_reg : key_reg;
            out_hdl_reg    <= (found_reg && (act_reg == ACT_HDL_BY_KEY ||
                               act_reg == ACT_TAKE_XID)) ? fnd_hdl_reg : hdl_reg;
            out_xid_reg    <= (found_reg && act_reg == ACT_TAKE_XID)
                              ? fnd_xid_reg : xid_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign key_out    = out_key_reg;
    assign handle_out = out_hdl_reg;
    assign xid_out    = out_xid_reg;
endmodule

@@ rtl/core/connection_hash_table.sv @@
`timescale 1ns / 1ps
// Sequence: a request is loaded; key probes first reduce the key mod size when the table size
// is not a power of two; slots are then probed in turn until one decides or all have been read,
// the slot is updated if needed, and the response is loaded. A spare action or a lookup with
// nothing to search by goes straight to the response. Only one transaction is in flight at a
// time; the next request is taken in the cycle after the response is loaded.
// Reset: after rst_n the slot memory is swept clear, slot by slot, before requests are taken.
// ============================================================================
// connection_hash_table
// Linear-probing connection table keyed by a 64-bit key, holding a handle and
// a transaction id per slot.
// ============================================================================
module connection_hash_table #(
    parameter int TABLE_SLOTS = cht_pkg::TABLE_SLOTS_DEF
) (
    input logic   clk,
    input logic   rst_n,
    cht_req_if.sink   req,
    cht_rsp_if.source rsp
);
    import cht_pkg::*;

    cht_cmd_t  cmd;
    cht_stat_t stat;
    logic      in_ready;

    cht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cht_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .action     (req.action),
        .key        (req.key),
        .handle     (req.handle),
        .xid_in     (req.xid_in),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .status     (rsp.status),
        .key_out    (rsp.key_out),
        .handle_out (rsp.handle_out),
        .xid_out    (rsp.xid_out)
    );

    assign req.ready = in_ready;
endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking regression of the connection hash table. Requests are driven
// through the request channel with random gaps, and every response is checked
// field by field against a shadow copy of the slot store that is updated as
// each request is accepted. Directed tests cover the empty table, probe
// wrap-around, the transaction id roll-over, handle scans, the spare action
// codes and a completely full table; random traffic over a small key pool
// follows, with a long response hold-off that backs the block up.
// ============================================================================
module testbench;
    import cht_pkg::*;

    localparam int SLOTS        = TABLE_SLOTS_DEF;
    localparam int KEY_POOL     = 40;
    localparam int HDL_POOL     = 16;
    localparam int DRAIN_ITEMS  = 120;
    localparam int RANDOM_ITEMS = 140;
    localparam int CYCLE_LIMIT  = 1000000;

    // Action codes that the block does not define; they must answer not found.
    localparam logic [ACT_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [KEY_W-1:0] key;
        logic [HDL_W-1:0] handle;
        logic [XID_W-1:0] xid;
    } conn_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    cht_req_if req_ch ();
    cht_rsp_if rsp_ch ();

    connection_hash_table #(
        .TABLE_SLOTS(SLOTS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow of the slot store, advanced as each request is accepted.
    logic [KEY_W-1:0] table_key    [SLOTS];
    logic [HDL_W-1:0] table_handle [SLOTS];
    logic [XID_W-1:0] table_xid    [SLOTS];

    logic [KEY_W-1:0] key_pool [KEY_POOL];
    logic [HDL_W-1:0] hdl_pool [HDL_POOL];

    conn_reply_t expected_replies [$];

    bit     idling_on = 1'b1;
    int     hold_off_cycles = 0;
    int     error_count = 0;
    int     requests_sent = 0;
    int     replies_checked = 0;
    int     status_seen [8];
    longint cycle_count = 0;

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("connection_hash_table regression: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (!idling_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        if (k == '0)
            k = 64'd1;
        return k;
    endfunction

    function automatic int probe_key(input logic [KEY_W-1:0] key);
        int start;
        int slot;
        if (key == '0)
            return -1;
        start = int'(key % SLOTS);
        for (int n = 0; n < SLOTS; n++)
        begin
            slot = (start + n) % SLOTS;
            if (table_key[slot] == key)
                return slot;
        end
        return -1;
    endfunction

    // Empty slots never match, whatever handle they still hold.
    function automatic int scan_handle(input logic [HDL_W-1:0] handle);
        for (int s = 0; s < SLOTS; s++)
            if (table_key[s] != '0 && table_handle[s] == handle)
                return s;
        return -1;
    endfunction

    function automatic int occupied_slots();
        int count;
        count = 0;
        for (int s = 0; s < SLOTS; s++)
            if (table_key[s] != '0)
                count++;
        return count;
    endfunction

    function automatic conn_reply_t predict_reply(input logic [ACT_W-1:0] action,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [HDL_W-1:0] handle,
                                                  input logic [XID_W-1:0] xid);
        conn_reply_t rp;
        int          slot;
        int          start;
        rp.status = ST_NOT_FOUND;
        rp.key    = key;
        rp.handle = handle;
        rp.xid    = xid;
        case (action)
            ACT_INSERT:
            begin
                // A key of zero compares equal to any empty slot, so it ends as
                // a duplicate without writing anything.
                rp.status = ST_FULL;
                start = int'(key % SLOTS);
                for (int n = 0; n < SLOTS; n++)
                begin
                    slot = (start + n) % SLOTS;
                    if (table_key[slot] == key)
                    begin
                        rp.status = ST_DUPLICATE;
                        break;
                    end
                    if (table_key[slot] == '0)
                    begin
                        table_key[slot]    = key;
                        table_handle[slot] = handle;
                        table_xid[slot]    = xid;
                        rp.status = ST_INSERTED;
                        break;
                    end
                end
            end
            ACT_REMOVE:
            begin
                slot = scan_handle(handle);
                if (slot >= 0)
                begin
                    rp.key = table_key[slot];
                    table_key[slot]    = '0;
                    table_handle[slot] = '0;
                    table_xid[slot]    = '0;
                    rp.status = ST_REMOVED;
                end
            end
            ACT_HDL_BY_KEY:
            begin
                slot = probe_key(key);
                if (slot >= 0)
                begin
                    rp.handle = table_handle[slot];
                    rp.status = ST_FOUND;
                end
            end
            ACT_KEY_BY_HDL:
            begin
                slot = scan_handle(handle);
                if (slot >= 0)
                begin
                    rp.key = table_key[slot];
                    rp.status = ST_FOUND;
                end
            end
            ACT_TAKE_XID:
            begin
                slot = -1;
                if (key != '0)
                    slot = probe_key(key);
                else if (handle != '0)
                    slot = scan_handle(handle);
                if (slot >= 0)
                begin
                    rp.key    = table_key[slot];
                    rp.handle = table_handle[slot];
                    rp.xid    = table_xid[slot];
                    table_xid[slot] = table_xid[slot] + 32'd1;
                    rp.status = ST_FOUND;
                end
            end
            default:
            begin
            end
        endcase
        return rp;
    endfunction

    // Offers one request after a random gap and records its expected response
    // once the transaction has been accepted.
    task automatic issue_request(input logic [ACT_W-1:0] action,
                                 input logic [KEY_W-1:0] key,
                                 input logic [HDL_W-1:0] handle,
                                 input logic [XID_W-1:0] xid);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= action;
        req_ch.key    <= key;
        req_ch.handle <= handle;
        req_ch.xid_in <= xid;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_replies.push_back(predict_reply(action, key, handle, xid));
        requests_sent++;
    endtask

    task automatic release_request();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    initial
    begin : rsp_ready_driver
        int stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (stall_left == 0 && idling_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    stall_left--;
                    rsp_ch.ready <= 1'b0;
                end
                else
                    rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        conn_reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("response with no request outstanding: status %0d key %h",
                       rsp_ch.status, rsp_ch.key_out);
                error_count++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.key_out !== want.key)
                begin
                    $error("key_out: expected %h, got %h", want.key, rsp_ch.key_out);
                    error_count++;
                end
                if (rsp_ch.handle_out !== want.handle)
                begin
                    $error("handle_out: expected %h, got %h", want.handle, rsp_ch.handle_out);
                    error_count++;
                end
                if (rsp_ch.xid_out !== want.xid)
                begin
                    $error("xid_out: expected %h, got %h", want.xid, rsp_ch.xid_out);
                    error_count++;
                end
                status_seen[want.status]++;
                replies_checked++;
            end
        end
    end

    task automatic test_empty_table();
        issue_request(ACT_KEY_BY_HDL, 64'd0, 16'h0000, 32'd0);
        issue_request(ACT_HDL_BY_KEY, 64'd1, 16'h0001, 32'd1);
        issue_request(ACT_TAKE_XID, 64'd0, 16'h0000, 32'h1234_5678);
        issue_request(ACT_INSERT, 64'd0, 16'h0042, 32'h0000_0042);
        issue_request(ACT_REMOVE, 64'd5, 16'h0005, 32'd5);
        issue_request(ACT_HDL_BY_KEY, 64'd0, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    // The all-ones key lands in the top slot, so a second key with the same
    // low byte has to wrap round to slot zero.
    task automatic test_wrap_and_xid();
        issue_request(ACT_INSERT, '1, 16'hFFFF, 32'hFFFF_FFFF);
        issue_request(ACT_INSERT, 64'h1FF, 16'h0000, 32'h8000_0000);
        issue_request(ACT_INSERT, '1, 16'h0001, 32'h0000_0001);
        issue_request(ACT_HDL_BY_KEY, 64'h1FF, 16'h5555, 32'd0);
        issue_request(ACT_TAKE_XID, '1, 16'h0000, 32'd0);
        issue_request(ACT_TAKE_XID, '1, 16'h0000, 32'd0);
        issue_request(ACT_TAKE_XID, 64'd0, 16'hFFFF, 32'd7);
        issue_request(ACT_TAKE_XID, 64'd0, 16'h0000, 32'd9);
        issue_request(ACT_REMOVE, 64'd0, 16'hFFFF, 32'd0);
        issue_request(ACT_HDL_BY_KEY, '1, 16'h0000, 32'd0);
    endtask

    task automatic test_handle_scans();
        issue_request(ACT_INSERT, 64'h10, 16'h1234, 32'hA5A5_0001);
        issue_request(ACT_INSERT, 64'h20, 16'h1234, 32'hA5A5_0002);
        issue_request(ACT_REMOVE, 64'd0, 16'h1234, 32'd0);
        issue_request(ACT_KEY_BY_HDL, 64'd0, 16'h1234, 32'd0);
    endtask

    task automatic test_spare_actions();
        issue_request(ACT_SPARE_5, '1, 16'h1234, 32'hFFFF_FFFF);
        issue_request(ACT_SPARE_6, 64'h20, 16'h1234, 32'h0);
        issue_request(ACT_SPARE_7, 64'h1FF, 16'hFFFF, 32'h5A5A_5A5A);
    endtask

    task automatic test_fill_to_capacity();
        int slot;
        while (occupied_slots() < SLOTS)
            issue_request(ACT_INSERT, random_key(), 16'($urandom), $urandom());
        issue_request(ACT_INSERT, random_key(), 16'($urandom), $urandom());
        issue_request(ACT_INSERT, 64'd0, 16'($urandom), $urandom());
        slot = $urandom_range(0, SLOTS - 1);
        issue_request(ACT_HDL_BY_KEY, table_key[slot], 16'd0, 32'd0);
        issue_request(ACT_HDL_BY_KEY, random_key(), 16'd0, 32'd0);
        issue_request(ACT_TAKE_XID, 64'd0, table_handle[SLOTS - 1], 32'd0);
        // Thin the table out again by handle, leaving long probe chains behind.
        repeat (DRAIN_ITEMS)
        begin
            slot = $urandom_range(0, SLOTS - 1);
            while (table_key[slot] == '0)
                slot = (slot + 1) % SLOTS;
            issue_request(ACT_REMOVE, random_key(), table_handle[slot], $urandom());
        end
    endtask

    task automatic test_random_traffic();
        int               roll;
        int               pick;
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key;
        logic [HDL_W-1:0] handle;
        // Pool keys share a few low bytes so that their probe paths collide.
        for (int i = 0; i < KEY_POOL; i++)
        begin
            key_pool[i] = random_key();
            if (i % 6 == 0)
                key_pool[i][7:0] = 8'hFF;
            else
                key_pool[i][7:0] = 8'($urandom_range(0, 7));
        end
        hdl_pool[0] = 16'h0000;
        hdl_pool[1] = 16'hFFFF;
        for (int i = 2; i < HDL_POOL; i++)
            hdl_pool[i] = 16'($urandom);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 25 == 0)
                idling_on = ($urandom_range(0, 4) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 30)
                action = ACT_INSERT;
            else if (roll < 45)
                action = ACT_REMOVE;
            else if (roll < 65)
                action = ACT_HDL_BY_KEY;
            else if (roll < 80)
                action = ACT_KEY_BY_HDL;
            else if (roll < 95)
                action = ACT_TAKE_XID;
            else
                action = 3'($urandom_range(ACT_SPARE_5, ACT_SPARE_7));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                key = '0;
            else if (pick == 1)
                key = random_key();
            else
                key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            if ($urandom_range(0, 4) == 0)
                handle = 16'($urandom);
            else
                handle = hdl_pool[$urandom_range(0, HDL_POOL - 1)];
            issue_request(action, key, handle, $urandom());
        end
        idling_on = 1'b1;
    endtask

    // The response side holds off for a long stretch while requests keep
    // coming, so the block has to stall its request channel.
    task automatic test_response_backpressure();
        idling_on = 1'b0;
        hold_off_cycles = 400;
        repeat (8)
            issue_request(ACT_TAKE_XID, key_pool[$urandom_range(0, KEY_POOL - 1)],
                          hdl_pool[$urandom_range(0, HDL_POOL - 1)], $urandom());
        idling_on = 1'b1;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.action = ACT_INSERT;
        req_ch.key    = '0;
        req_ch.handle = '0;
        req_ch.xid_in = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            table_key[s]    = '0;
            table_handle[s] = '0;
            table_xid[s]    = '0;
        end
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_wrap_and_xid();
        test_handle_scans();
        test_spare_actions();
        test_fill_to_capacity();
        test_random_traffic();
        test_response_backpressure();

        release_request();
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 32) @(posedge clk);

        $display("Run covered %0d requests and %0d checked responses: %0d inserted, %0d duplicate,",
                 requests_sent, replies_checked, status_seen[ST_INSERTED],
                 status_seen[ST_DUPLICATE]);
        $display("  %0d table full, %0d removed, %0d found, %0d not found.",
                 status_seen[ST_FULL], status_seen[ST_REMOVED], status_seen[ST_FOUND],
                 status_seen[ST_NOT_FOUND]);
        if (error_count == 0)
            $display("connection_hash_table regression: pass");
        else
            $display("connection_hash_table regression: fail");
        $finish;
    end
endmodule
